[src/blsel_pkg.sv]
package blsel_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned HoldW = 16;
  localparam logic [HoldW-1:0] HOLD_RESET = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SELECT = 2'd1,
    PH_LOCKED = 2'd2
  } phase_t;

  localparam logic [1:0] MODE_ONE   = 2'd0;
  localparam logic [1:0] MODE_TWO   = 2'd1;
  localparam logic [1:0] MODE_THREE = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             mode_pressed;
    logic             confirm_pressed;
    logic             restart;
  } in_word_t;

  typedef struct packed {
    logic [1:0] selector_state;
    logic       locked;
    logic [1:0] mode;
    logic       led_a;
    logic       led_b;
    logic       led_c;
  } out_word_t;

  typedef struct packed {
    phase_t           phase;
    logic [1:0]       mode_reg;
    logic             mode_held;
    logic             confirm_held;
    logic [TimeW-1:0] press_start;
  } sel_state_t;

endpackage

[src/button_long_press_mode_selector_core.sv]
// Path: an accepted word passes through the input register, then the result
//   register; the selector state updates as a word moves between them.
// Throughput: one word per cycle while the result side is not stalled; the single update step sets the rate.
// Reset: rst, synchronous and active high, empties both registers, returns the
//   selector to idle at mode one and sets the hold time to 2000 ms.
module button_long_press_mode_selector_core
  import blsel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration: hold time in ms
  input  logic             cfg_we,
  input  logic [HoldW-1:0] cfg_data,
  // sample channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data
);

  logic [HoldW-1:0] hold_ms;

  // input register
  logic     in_v;
  in_word_t in_word;

  // selector state
  sel_state_t st;
  sel_state_t st_next;

  out_word_t res;
  logic      advance;
  logic      accept;

  // A held word moves on when the result register is empty or being drained,
  // so the input side keeps taking a word each cycle while results flow.
  assign advance  = in_v && (!out_valid || !out_stall);
  assign in_stall = in_v && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms <= HOLD_RESET;
    end else if (cfg_we) begin
      hold_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (accept) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= in_data;
    end
  end

  // update logic: edge detection, elapsed time compare, phase and mode step
  blsel_step u_step (
    .hold_ms (hold_ms),
    .word    (in_word),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  // state commits only when its word is handed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_IDLE;
      st.mode_reg     <= MODE_ONE;
      st.mode_held    <= 1'b0;
      st.confirm_held <= 1'b0;
      st.press_start  <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  // --- checks ---

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("selector state changed without a word moving on");

  a_restart_idle: assert property (@(posedge clk) disable iff (rst)
    advance && in_word.restart |=>
      out_data.selector_state == PH_IDLE && out_data.mode == MODE_ONE)
    else $error("restart did not return to idle at mode one");

  a_lock_leds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.locked |->
      out_data.led_a && out_data.led_b && out_data.led_c &&
      out_data.selector_state == PH_LOCKED)
    else $error("locked word without all LEDs lit");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mode != 2'd3)
    else $error("unused mode code on output");

endmodule

[src/blsel_step.sv]
module blsel_step
  import blsel_pkg::*;
(
  input  logic [HoldW-1:0] hold_ms,
  input  in_word_t         word,
  input  sel_state_t       st,
  output sel_state_t       st_next,
  output out_word_t        res
);

  logic [TimeW-1:0] start_ts;
  logic [TimeW-1:0] elapsed;
  logic             hold_done;
  logic [1:0]       mode_step;
  logic             lk;

  // confirm timing: a fresh press restarts the timer
  always_comb begin
    start_ts  = (word.confirm_pressed && !st.confirm_held) ? word.now_ms : st.press_start;
    elapsed   = word.now_ms - start_ts;
    hold_done = word.confirm_pressed && (elapsed >= {{(TimeW-HoldW){1'b0}}, hold_ms});
  end

  always_comb begin
    unique case (st.mode_reg)
      MODE_ONE: begin
        mode_step = MODE_TWO;
      end
      MODE_TWO: begin
        mode_step = MODE_THREE;
      end
      default: begin
        mode_step = MODE_ONE;
      end
    endcase
  end

  always_comb begin
    st_next = st;
    if (word.restart) begin
      st_next.phase        = PH_IDLE;
      st_next.mode_reg     = MODE_ONE;
      st_next.mode_held    = 1'b0;
      st_next.confirm_held = 1'b0;
      st_next.press_start  = '0;
    end else begin
      unique case (st.phase)
        PH_IDLE, PH_SELECT: begin
          if (word.mode_pressed && !st.mode_held) begin
            st_next.phase    = PH_SELECT;
            st_next.mode_reg = mode_step;
          end
          st_next.mode_held    = word.mode_pressed;
          st_next.press_start  = start_ts;
          st_next.confirm_held = word.confirm_pressed && !hold_done;
          if (hold_done) begin
            st_next.phase = PH_LOCKED;
          end
        end
        PH_LOCKED: begin
          st_next.press_start  = start_ts;
          st_next.confirm_held = word.confirm_pressed && !hold_done;
          if (hold_done) begin
            st_next.phase    = PH_IDLE;
            st_next.mode_reg = MODE_ONE;
          end
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

  always_comb begin
    lk                 = (st_next.phase == PH_LOCKED);
    res.selector_state = st_next.phase;
    res.locked         = lk;
    res.mode           = st_next.mode_reg;
    res.led_a          = lk || (st_next.mode_reg == MODE_ONE);
    res.led_b          = lk || (st_next.mode_reg == MODE_TWO);
    res.led_c          = lk || (st_next.mode_reg == MODE_THREE);
  end

endmodule

[sim/button_long_press_mode_selector_core_test.sv]
module button_long_press_mode_selector_core_test
  import blsel_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Selector predictor and expected-result queue. note_sample() runs the
  // selector on each accepted sample word. check_result() compares each
  // result word with the oldest expectation.
  class sel_scoreboard;
    logic [HoldW-1:0] hold_ms;
    phase_t           phase;
    logic [1:0]       mode_reg;
    logic             mode_held;
    logic             confirm_held;
    logic [TimeW-1:0] press_start;
    out_word_t        pending[$];
    int               errors;
    int               n_seen;

    function new();
      hold_ms = HOLD_RESET;
      errors  = 0;
      n_seen  = 0;
      clear();
    endfunction

    function void clear();
      phase        = PH_IDLE;
      mode_reg     = MODE_ONE;
      mode_held    = 1'b0;
      confirm_held = 1'b0;
      press_start  = '0;
    endfunction

    // Confirm timing. It returns 1 once the hold time has passed, and then
    // drops confirm_held so that a button still held starts a fresh press.
    function bit hold_reached(logic [TimeW-1:0] now, logic pressed);
      logic [TimeW-1:0] elapsed;
      bit               done;
      done = 1'b0;
      if (pressed && !confirm_held) begin
        confirm_held = 1'b1;
        press_start  = now;
      end
      elapsed = now - press_start;
      if (pressed && confirm_held && elapsed >= hold_ms) begin
        done         = 1'b1;
        confirm_held = 1'b0;
      end
      if (!pressed) confirm_held = 1'b0;
      return done;
    endfunction

    function void note_sample(in_word_t w);
      out_word_t exp;
      logic      lk;
      if (w.restart) begin
        clear();
      end else if (phase == PH_IDLE || phase == PH_SELECT) begin
        if (w.mode_pressed && !mode_held) begin
          mode_held = 1'b1;
          phase     = PH_SELECT;
          case (mode_reg)
            MODE_ONE: mode_reg = MODE_TWO;
            MODE_TWO: mode_reg = MODE_THREE;
            default:  mode_reg = MODE_ONE;
          endcase
        end
        if (!w.mode_pressed) mode_held = 1'b0;
        if (hold_reached(w.now_ms, w.confirm_pressed)) phase = PH_LOCKED;
      end else if (phase == PH_LOCKED) begin
        // the mode button is ignored here; mode_held keeps its value
        if (hold_reached(w.now_ms, w.confirm_pressed)) begin
          phase    = PH_IDLE;
          mode_reg = MODE_ONE;
        end
      end
      lk                 = (phase == PH_LOCKED);
      exp.selector_state = phase;
      exp.locked         = lk;
      exp.mode           = mode_reg;
      exp.led_a          = lk || mode_reg == MODE_ONE;
      exp.led_b          = lk || mode_reg == MODE_TWO;
      exp.led_c          = lk || mode_reg == MODE_THREE;
      pending.push_back(exp);
    endfunction

    task report(string msg);
      $display("mismatch at result word %0d: %s", n_seen, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [1:0] got, logic [1:0] exp);
      if (got !== exp) report($sformatf("%s got %0d expected %0d", name, got, exp));
    endtask

    task check_result(out_word_t got);
      out_word_t exp;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        exp = pending.pop_front();
        cmp_field("selector_state", got.selector_state, exp.selector_state);
        cmp_field("locked", {1'b0, got.locked}, {1'b0, exp.locked});
        cmp_field("mode", got.mode, exp.mode);
        cmp_field("led_a", {1'b0, got.led_a}, {1'b0, exp.led_a});
        cmp_field("led_b", {1'b0, got.led_b}, {1'b0, exp.led_b});
        cmp_field("led_c", {1'b0, got.led_c}, {1'b0, exp.led_c});
      end
      n_seen++;
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [HoldW-1:0] cfg_data;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_data;

  sel_scoreboard sb;
  int unsigned   send_idle_pct; // chance per cycle that the sender holds off
  int unsigned   recv_stall_pct; // chance per cycle that the receiver stalls

  button_long_press_mode_selector_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: the stall changes on the falling edge. The result word is
  // taken at the rising edge, using the values that were settled before it.
  always @(negedge clk) begin
    out_stall = rst ? 1'b0 : ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Presents one sample word. Random hold-offs come first. The word then
  // stays on the bus, unchanged, until an edge at which the block is not
  // stalling. The task returns on the falling edge that follows.
  task automatic send_sample(logic [TimeW-1:0] now, logic mp, logic cp, logic rs);
    in_word_t w;
    w.now_ms          = now;
    w.mode_pressed    = mp;
    w.confirm_pressed = cp;
    w.restart         = rs;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    sb.note_sample(w);
    @(negedge clk);
  endtask

  // Waits until every expected result word has come back, with the input idle,
  // and then lets the two-stage pipeline empty.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Hold-time write. The block is idle at this point, and the selector state
  // is kept.
  task automatic write_hold(logic [HoldW-1:0] v);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.hold_ms = v;
  endtask

  // Button traffic that is mostly well-formed. The levels toggle now and then,
  // and the timestamp moves forward in steps scaled to the hold time, so that
  // locks and unlocks come about often. Some words are pure noise, some
  // jump in time, and an odd one is a restart.
  task automatic run_random(int count);
    logic [TimeW-1:0] now_t;
    logic             mp;
    logic             cp;
    int unsigned      span;
    now_t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(200000) : $urandom;
    mp    = 1'b0;
    cp    = 1'b0;
    span  = (sb.hold_ms == 0) ? 3 : sb.hold_ms / 2 + 1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        send_sample($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end else begin
        if ($urandom_range(99) < 5) now_t = $urandom;
        else now_t += $urandom_range(span);
        if ($urandom_range(99) < 30) mp = ~mp;
        if ($urandom_range(99) < 15) cp = ~cp;
        send_sample(now_t, mp, cp, $urandom_range(49) == 0);
      end
    end
  endtask

  initial begin
    sb             = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: write_hold('0);
          2: write_hold(16'd1);
          3: write_hold(16'hFFFF);
          4: write_hold(16'd7);
          5: write_hold(HoldW'($urandom_range(200, 2)));
          6: write_hold(HoldW'($urandom_range(65535, 1)));
          default: write_hold(HOLD_RESET);
        endcase
      end
      // idling pattern: none, sender, receiver, then both sides lightly
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase

      if (p == 0) begin
        // hold time at its reset value of 2000 ms
        send_sample(32'd0, 1'b0, 1'b0, 1'b0);
        send_sample(32'd10, 1'b1, 1'b0, 1'b0);  // first press -> mode two
        send_sample(32'd20, 1'b1, 1'b0, 1'b0);  // still held, no change
        send_sample(32'd30, 1'b0, 1'b0, 1'b0);
        send_sample(32'd40, 1'b1, 1'b0, 1'b0);  // mode three
        send_sample(32'd50, 1'b0, 1'b0, 1'b0);
        send_sample(32'd60, 1'b1, 1'b0, 1'b0);  // wraps to mode one
        send_sample(32'd70, 1'b0, 1'b1, 1'b0);  // confirm press starts timing
        send_sample(32'd2069, 1'b0, 1'b1, 1'b0); // one ms short
        send_sample(32'd2070, 1'b0, 1'b1, 1'b0); // exactly the hold -> locked
        send_sample(32'd2080, 1'b0, 1'b1, 1'b0); // still held counts as new press
        send_sample(32'd2090, 1'b1, 1'b1, 1'b0); // mode ignored while locked
        send_sample(32'hFFFF_FC00, 1'b1, 1'b0, 1'b0);
        send_sample(32'hFFFF_FC00, 1'b1, 1'b1, 1'b0);
        send_sample(32'h0000_0400, 1'b1, 1'b1, 1'b0); // across the wrap -> unlock
        // mode_held was never set while locked, so this counts as an edge
        send_sample(32'h0000_0410, 1'b1, 1'b0, 1'b0);
        send_sample(32'h0000_0420, 1'b0, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1); // restart wins over buttons
        send_sample(32'd0, 1'b0, 1'b0, 1'b0);
      end else if (p == 1) begin
        // zero hold: lock and unlock on the press edge itself
        send_sample(32'd5, 1'b0, 1'b1, 1'b0);
        send_sample(32'd6, 1'b0, 1'b0, 1'b0);
        send_sample(32'd7, 1'b0, 1'b1, 1'b0);
        send_sample(32'd8, 1'b1, 1'b1, 1'b0);
      end
      run_random(105);
    end

    drain();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
src/blsel_pkg.sv
src/blsel_step.sv
src/button_long_press_mode_selector_core.sv
sim/button_long_press_mode_selector_core_test.sv
